FILE: hdl/lkt_pkg.sv
// lkt_pkg: shared types and constants for the lru key tracker
// request and response payloads, the scan token passed along the cell row
// and the update broadcast; no dependencies
package lkt_pkg;

   localparam int KEY_W           = 8;
   localparam int SLOT_W          = 3;
   localparam int DEFAULT_ENTRIES = 8;
   localparam int MAX_ENTRIES     = 64;
   // index and age width wide enough for the largest table
   localparam int IDX_W           = $clog2(MAX_ENTRIES);

   typedef struct packed {
      logic [KEY_W-1:0] area;
      logic [KEY_W-1:0] room;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
   } rsp_type;

   // token that walks the cell row, one cell a cycle
   typedef struct packed {
      logic             valid;
      req_type          key;
      logic             found;
      logic [IDX_W-1:0] match_idx;
      logic [IDX_W-1:0] match_age;
      logic [IDX_W-1:0] best_idx;
      logic [IDX_W-1:0] best_age;
   } scan_type;

   // broadcast to every cell once the token leaves the last cell
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [IDX_W-1:0] pick;
      logic [IDX_W-1:0] pick_age;
      req_type          key;
   } update_type;

endpackage

FILE: hdl/lkt_cell.sv
// lkt_cell: one slot of the tracker holding key and age
// folds its slot into the passing scan token and applies the update broadcast
// depends on lkt_pkg
module lkt_cell #(
   parameter int ENTRIES    = lkt_pkg::DEFAULT_ENTRIES,
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  lkt_pkg::scan_type   scan_in,
   output lkt_pkg::scan_type   scan_out,
   input  lkt_pkg::update_type upd
);

   localparam int AGE_W = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;

   logic [lkt_pkg::KEY_W-1:0] area_ff;
   logic [lkt_pkg::KEY_W-1:0] room_ff;
   logic [AGE_W-1:0]          age_ff;
   lkt_pkg::scan_type         scan_ff;
   lkt_pkg::scan_type         scan_in_next;
   logic [lkt_pkg::IDX_W-1:0] age_wide;
   logic [lkt_pkg::IDX_W-1:0] my_idx;
   logic                      key_match;

   assign age_wide  = lkt_pkg::IDX_W'(age_ff);
   assign my_idx    = lkt_pkg::IDX_W'(CELL_INDEX);
   assign key_match = (area_ff == scan_in.key.area) && (room_ff == scan_in.key.room);

   // fold this slot into the token: first match, then oldest with lowest index
   always_comb begin
      scan_in_next = scan_in;
      if (!scan_in.found && key_match) begin
         scan_in_next.found     = 1'b1;
         scan_in_next.match_idx = my_idx;
         scan_in_next.match_age = age_wide;
      end
      if (age_wide > scan_in.best_age) begin
         scan_in_next.best_idx = my_idx;
         scan_in_next.best_age = age_wide;
      end
   end

   // token register towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.valid <= 1'b0;
      end else begin
         scan_ff <= scan_in_next;
      end
   end

   assign scan_out = scan_ff;

   // slot contents: replace on miss; all age on a miss, only younger on a hit
   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff <= '0;
         room_ff <= '0;
         age_ff  <= '0;
      end else if (upd.valid) begin
         if (my_idx == upd.pick) begin
            age_ff <= '0;
            if (!upd.hit) begin
               area_ff <= upd.key.area;
               room_ff <= upd.key.room;
            end
         end else if (!upd.hit || (age_wide < upd.pick_age)) begin
            age_ff <= age_ff + 1'b1;
         end
      end
   end

endmodule

FILE: hdl/lru_key_tracker.sv
// the accepted token walks the cell row one slot a cycle, then the update
// broadcast is registered into rsp_strobe and rsp_payload; no new request is
// taken while busy, and busy falls in the cycle the response shows
// reset: synchronous, clears all keys and ages to zero and empties the row
// the receiver cannot stall: each response is shown for exactly one cycle
//
// lru_key_tracker: top level, a row of lkt_cell slots plus the update logic
// depends on lkt_pkg and lkt_cell
module lru_key_tracker #(
   parameter int ENTRIES = lkt_pkg::DEFAULT_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lkt_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output lkt_pkg::rsp_type rsp_payload
);

   lkt_pkg::scan_type   scan_chain [ENTRIES+1];
   lkt_pkg::scan_type   scan_last;
   lkt_pkg::update_type upd;
   logic                busy_ff;
   logic                rsp_strobe_ff;
   lkt_pkg::rsp_type    rsp_ff;
   logic                accept;

   assign accept = start && !busy_ff;

   // head token: nothing found yet, slot 0 as the provisional oldest
   always_comb begin
      scan_chain[0]           = '0;
      scan_chain[0].valid     = accept;
      scan_chain[0].key       = req_payload;
   end

   // the row of slots
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkt_cell #(
         .ENTRIES    (ENTRIES),
         .CELL_INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .scan_in  (scan_chain[i]),
         .scan_out (scan_chain[i+1]),
         .upd      (upd)
      );
   end

   assign scan_last = scan_chain[ENTRIES];

   // update broadcast once the token has passed every slot
   always_comb begin
      upd.valid    = scan_last.valid;
      upd.hit      = scan_last.found;
      upd.pick     = scan_last.found ? scan_last.match_idx : scan_last.best_idx;
      upd.pick_age = scan_last.match_age;
      upd.key      = scan_last.key;
   end

   // busy flag and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= upd.valid;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (upd.valid) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.valid) begin
         rsp_ff.slot <= upd.pick[lkt_pkg::SLOT_W-1:0];
         rsp_ff.hit  <= upd.hit;
      end
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/lkt_checker.sv
// lkt_checker: port-level checks on the lru key tracker handshake
// bound to lru_key_tracker below; depends on nothing else
module lkt_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted request");

   // a response only shows once the block has gone idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // busy falls exactly with the response
   a_fall_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy fell without a response");

   // responses never come two in a row
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

endmodule

bind lru_key_tracker lkt_checker u_lkt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

FILE: tb/tb_top.sv
// tb_top: self-checking bench for lru_key_tracker, a directed table then random lookups
// every response is checked against the typed table value or else an in-bench lru age predictor
// depends on lkt_pkg and lru_key_tracker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES    = lkt_pkg::DEFAULT_ENTRIES;
   localparam int RAND_ITEMS = 1950;
   localparam int CYCLE_CAP  = 400000;
   localparam int N_ROWS     = 22;

   // one row of the directed table, expected response only where typed in
   typedef struct packed {
      logic [lkt_pkg::KEY_W-1:0]  area;
      logic [lkt_pkg::KEY_W-1:0]  room;
      logic                       typed;
      logic [lkt_pkg::SLOT_W-1:0] slot;
      logic                       hit;
   } dir_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   lkt_pkg::req_type req_payload = '0;
   logic             busy;
   logic             rsp_strobe;
   lkt_pkg::rsp_type rsp_payload;

   // typed expectation travelling with the current request
   logic             row_typed = 1'b0;
   lkt_pkg::rsp_type row_rsp   = '0;

   // predictor copy of the slot table
   logic [lkt_pkg::KEY_W-1:0] tag_area [ENTRIES];
   logic [lkt_pkg::KEY_W-1:0] tag_room [ENTRIES];
   logic [lkt_pkg::IDX_W-1:0] tag_age  [ENTRIES];

   lkt_pkg::rsp_type pending_rsp [$];
   int               fail_count = 0;
   int               cycle_count = 0;

   dir_row_type dir_rows [N_ROWS] = '{
      // after reset every slot holds key zero: lowest index wins
      '{8'h00, 8'h00, 1'b1, 3'd0, 1'b1},
      // all ages equal, so the miss lands in slot zero
      '{8'hff, 8'hff, 1'b1, 3'd0, 1'b0},
      // key zero now first found in slot one
      '{8'h00, 8'h00, 1'b1, 3'd1, 1'b1},
      '{8'hff, 8'h00, 1'b0, 3'd0, 1'b0},
      '{8'h00, 8'hff, 1'b0, 3'd0, 1'b0},
      '{8'haa, 8'h55, 1'b0, 3'd0, 1'b0},
      '{8'h55, 8'haa, 1'b0, 3'd0, 1'b0},
      '{8'h01, 8'h80, 1'b0, 3'd0, 1'b0},
      '{8'h80, 8'h01, 1'b0, 3'd0, 1'b0},
      '{8'hff, 8'hff, 1'b0, 3'd0, 1'b0},
      '{8'haa, 8'h55, 1'b0, 3'd0, 1'b0},
      '{8'h00, 8'h00, 1'b0, 3'd0, 1'b0},
      // fresh keys push out the oldest slots
      '{8'h12, 8'h34, 1'b0, 3'd0, 1'b0},
      '{8'h56, 8'h78, 1'b0, 3'd0, 1'b0},
      '{8'h9a, 8'hbc, 1'b0, 3'd0, 1'b0},
      '{8'hde, 8'hf0, 1'b0, 3'd0, 1'b0},
      // repeat of the youngest key, then of an older one
      '{8'hde, 8'hf0, 1'b0, 3'd0, 1'b0},
      '{8'hde, 8'hf0, 1'b0, 3'd0, 1'b0},
      '{8'h12, 8'h34, 1'b0, 3'd0, 1'b0},
      '{8'hfe, 8'h7f, 1'b0, 3'd0, 1'b0},
      '{8'h7f, 8'hfe, 1'b0, 3'd0, 1'b0},
      '{8'hff, 8'hff, 1'b0, 3'd0, 1'b0}
   };

   lru_key_tracker #(.ENTRIES(ENTRIES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // lookup in the predictor table with lru age update
   task automatic model_lookup(input lkt_pkg::req_type k, output lkt_pkg::rsp_type r);
      int                        pick;
      bit                        found;
      logic [lkt_pkg::IDX_W-1:0] pick_age;
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!found && tag_area[i] == k.area && tag_room[i] == k.room) begin
            pick  = i;
            found = 1'b1;
         end
      end
      // miss: oldest slot, ties to the lowest index
      if (!found) begin
         for (int i = 1; i < ENTRIES; i++) begin
            if (tag_age[i] > tag_age[pick])
               pick = i;
         end
         tag_area[pick] = k.area;
         tag_room[pick] = k.room;
      end
      pick_age = tag_age[pick];
      for (int i = 0; i < ENTRIES; i++) begin
         if (i != pick && (!found || tag_age[i] < pick_age))
            tag_age[i] = tag_age[i] + 1'b1;
      end
      tag_age[pick] = '0;
      r.slot = lkt_pkg::SLOT_W'(pick);
      r.hit  = found;
   endtask

   // request tracking and response checking
   always @(posedge clock) begin
      lkt_pkg::rsp_type predicted;
      lkt_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tag_area[i] = '0;
            tag_room[i] = '0;
            tag_age[i]  = '0;
         end
      end else begin
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $error("response with nothing outstanding: slot %0d hit %0d",
                      rsp_payload.slot, rsp_payload.hit);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_payload.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_payload.slot);
                  fail_count++;
               end
               if (rsp_payload.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_payload.hit);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            model_lookup(req_payload, predicted);
            pending_rsp.push_back(row_typed ? row_rsp : predicted);
         end
      end
   end

   // cycle cap
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // present one request, with an optional random gap first, and wait for it to be taken
   task automatic issue(input lkt_pkg::req_type k, input logic typed,
                        input lkt_pkg::rsp_type r, input bit gaps);
      int gap;
      gap = 0;
      if (gaps && $urandom_range(99) < 34)
         gap = $urandom_range(1, 2 * ENTRIES + 2);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= k;
      row_typed   <= typed;
      row_rsp     <= r;
      do @(posedge clock); while (busy);
   endtask

   // stimulus
   initial begin
      lkt_pkg::req_type key_pool [16];
      int               pool_n;
      lkt_pkg::req_type k;
      pool_n = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[i]) begin
         issue(lkt_pkg::req_type'{area: dir_rows[i].area, room: dir_rows[i].room},
               dir_rows[i].typed,
               lkt_pkg::rsp_type'{slot: dir_rows[i].slot, hit: dir_rows[i].hit}, 1'b1);
      end

      // random part: mostly keys from a small working set so hits and evictions mix
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 150 == 0) begin
            pool_n = $urandom_range(3, 14);
            for (int i = 0; i < 16; i++)
               key_pool[i] = lkt_pkg::req_type'(16'($urandom));
         end
         if ($urandom_range(99) < 75)
            k = key_pool[$urandom_range(pool_n - 1)];
         else
            k = lkt_pkg::req_type'(16'($urandom));
         // a long stretch with back-to-back requests
         issue(k, 1'b0, '0, !(n >= 700 && n < 1000));
      end
      start <= 1'b0;

      // drain and let any stray response show
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * ENTRIES + 4) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
